@@ rtl/twa_pkg.sv @@
// Shared types, sizes and codes of the table-driven word acceptor.
package twa_pkg;

    localparam int MAX_STATES = 16;
    localparam int MAX_EVENTS = 16;

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int SYM_W    = 8;
    localparam int ROW_W    = 16;
    localparam int STATE_W  = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam int ST_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int EV_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    localparam int QDEPTH = 2;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        K_LOAD_SYM   = 3'd0,
        K_LOAD_ROW   = 3'd1,
        K_LOAD_FINAL = 3'd2,
        K_CHAR       = 3'd3,
        K_EOW        = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        V_ACCEPT   = 2'd0,
        V_NONFINAL = 2'd1,
        V_UNKNOWN  = 2'd2,
        V_NO_TRANS = 2'd3
    } t_verdict;

    typedef struct packed {
        logic                             eow;
        logic                             found;
        logic [MAX_STATES-1:0][ROW_W-1:0] rows;
        logic [MAX_STATES-1:0]            finals;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

@@ rtl/twa_front.sv @@
// Front end: accepts items, updates the stores and classifies word items.
module twa_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [twa_pkg::KIND_W-1:0]      i_kind,
    input  logic [twa_pkg::INDEX_W-1:0]     i_state_index,
    input  logic [twa_pkg::INDEX_W-1:0]     i_event_index,
    input  logic [twa_pkg::SYM_W-1:0]       i_symbol,
    input  logic [twa_pkg::ROW_W-1:0]       i_row_targets,
    input  logic                            i_final_value,
    input  logic [twa_pkg::CFG_W-1:0]       i_event_count,
    input  twa_pkg::t_fifo_stat             i_q_stat,
    output logic                            o_push,
    output twa_pkg::t_job                   o_job
);
    import twa_pkg::*;

    logic [SYM_W-1:0]                 r_sym [MAX_EVENTS];
    logic [MAX_STATES-1:0]            r_row_vld [MAX_EVENTS];
    logic [MAX_STATES-1:0][ROW_W-1:0] r_rows_mem [MAX_EVENTS];
    logic [MAX_STATES-1:0]            r_final;

    logic                             r_s1_valid;
    logic                             r_s1_eow;
    logic                             r_s1_found;
    logic [MAX_STATES-1:0]            r_s1_finals;
    logic [MAX_STATES-1:0][ROW_W-1:0] r_rd_rows;
    logic [MAX_STATES-1:0]            r_rd_vld;

    logic            acc;
    logic            wr_sym;
    logic            wr_row;
    logic            wr_fin;
    logic            to_back;
    logic            hit;
    logic [EV_W-1:0] ev_hit;
    logic [EV_W-1:0] ev_wr;
    logic [ST_W-1:0] st_wr;

    assign o_in_ready = !r_s1_valid || !i_q_stat.full;
    assign acc        = i_in_valid && o_in_ready;
    assign o_push     = r_s1_valid && !i_q_stat.full;
    assign ev_wr      = EV_W'(i_event_index);
    assign st_wr      = ST_W'(i_state_index);

    always_comb begin
        wr_sym  = 1'b0;
        wr_row  = 1'b0;
        wr_fin  = 1'b0;
        to_back = 1'b0;
        if (acc) begin
            unique case (i_kind)
                K_LOAD_SYM:   wr_sym = 32'(i_event_index) < MAX_EVENTS;
                K_LOAD_ROW:   wr_row = (32'(i_event_index) < MAX_EVENTS) &&
                                       (32'(i_state_index) < MAX_STATES);
                K_LOAD_FINAL: wr_fin = 32'(i_state_index) < MAX_STATES;
                K_CHAR,
                K_EOW:        to_back = 1'b1;
                default:      ;
            endcase
        end
    end

    // highest matching entry below the event count wins
    always_comb begin
        hit    = 1'b0;
        ev_hit = '0;
        for (int j = 0; j < MAX_EVENTS; j++) begin
            if ((j < 32'(i_event_count)) && (r_sym[j] == i_symbol)) begin
                hit    = 1'b1;
                ev_hit = EV_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_EVENTS; j++) begin
                r_sym[j]     <= '0;
                r_row_vld[j] <= '0;
            end
            r_final    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (wr_sym) begin
                r_sym[ev_wr] <= i_symbol;
            end
            if (wr_row) begin
                r_row_vld[ev_wr][st_wr] <= 1'b1;
            end
            if (wr_fin) begin
                r_final[st_wr] <= i_final_value;
            end
            if (to_back) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_row) begin
            r_rows_mem[ev_wr][st_wr] <= i_row_targets;
        end
        if (to_back) begin
            r_rd_rows   <= r_rows_mem[ev_hit];
            r_rd_vld    <= r_row_vld[ev_hit];
            r_s1_eow    <= (i_kind == K_EOW);
            r_s1_found  <= hit;
            r_s1_finals <= r_final;
        end
    end

    always_comb begin
        o_job.eow    = r_s1_eow;
        o_job.found  = r_s1_found;
        o_job.finals = r_s1_finals;
        for (int s = 0; s < MAX_STATES; s++) begin
            o_job.rows[s] = r_rd_vld[s] ? r_rd_rows[s] : '0;
        end
    end

endmodule

@@ rtl/twa_fifo.sv @@
// Short job queue between the front end and the back end.
module twa_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  twa_pkg::t_job       i_data,
    input  logic                i_pop,
    output twa_pkg::t_job       o_data,
    output twa_pkg::t_fifo_stat o_stat
);
    import twa_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QA_W-1:0]  r_wr_ptr;
    logic [QA_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QC_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/twa_back.sv @@
// Back end: walks the automaton and issues the verdict of each word.
module twa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  twa_pkg::t_job               i_job,
    input  twa_pkg::t_fifo_stat         i_q_stat,
    output logic                        o_pop,
    input  logic [twa_pkg::CFG_W-1:0]   i_state_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_verdict,
    output logic [twa_pkg::STATE_W-1:0] o_end_state
);
    import twa_pkg::*;

    logic [STATE_W-1:0] r_cur;
    t_verdict           r_rej;
    logic               r_out_valid;
    t_verdict           r_verdict;
    logic [STATE_W-1:0] r_end_state;

    logic [STATE_W-1:0] n_cur;
    t_verdict           n_rej;
    logic               n_out_valid;
    t_verdict           eow_verdict;
    logic               out_free;
    logic               in_range;
    logic [ROW_W-1:0]   row;
    logic               nxt_hit;
    logic [STATE_W-1:0] nxt;
    logic               fin;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = !i_q_stat.empty && (!i_job.eow || out_free);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_end_state = r_end_state;
    assign in_range    = 32'(r_cur) < MAX_STATES;

    always_comb begin
        row = in_range ? i_job.rows[ST_W'(r_cur)] : '0;
        fin = in_range && i_job.finals[ST_W'(r_cur)];
        nxt_hit = 1'b0;
        nxt     = '0;
        for (int j = 0; j < ROW_W; j++) begin
            if (row[j] && (j < 32'(i_state_count)) && (j < MAX_STATES)) begin
                nxt_hit = 1'b1;
                nxt     = STATE_W'(j);
            end
        end
    end

    always_comb begin
        n_cur       = r_cur;
        n_rej       = r_rej;
        eow_verdict = (r_rej != V_ACCEPT) ? r_rej : (fin ? V_ACCEPT : V_NONFINAL);
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_pop) begin
            if (i_job.eow) begin
                n_cur       = '0;
                n_rej       = V_ACCEPT;
                n_out_valid = 1'b1;
            end else if (r_rej == V_ACCEPT) begin
                if (!i_job.found) begin
                    n_rej = V_UNKNOWN;
                end else if (!nxt_hit) begin
                    n_rej = V_NO_TRANS;
                end else begin
                    n_cur = nxt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_rej       <= V_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.eow) begin
            r_verdict   <= eow_verdict;
            r_end_state <= r_cur;
        end
    end

endmodule

@@ rtl/table_driven_word_acceptor_core.sv @@
// Top level of the table-driven word acceptor: configuration and block wiring.
//
// Input channel (i_in_valid / o_in_ready) takes one item per transfer: loads of the
// symbol table, transition rows and final flags, word characters and end-of-word marks.
// Output channel (o_out_valid / i_out_ready) gives one verdict and end state per
// end-of-word item; no other item gives a result.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 state count,
// 1 event count) at the clock edge; the user must write only while the block is idle,
// as the block itself does not enforce it. Throughput: one item per cycle while the
// queue has room; a character takes one pass of the back end (state row select, mask
// and priority encode) per cycle. A verdict passes from the lookup and row read at its
// end-of-word transfer through the queue to the walk and output register.
// A stalled receiver holds the verdict register; characters keep draining behind it
// until an end-of-word item reaches the back end, then the two-entry queue fills and
// o_in_ready drops.
// Reset (synchronous, active low) clears the symbol table and final flags, drops rows
// through per-row valid bits, sets state count 1, event count 0 and restarts at state 0.
module table_driven_word_acceptor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [twa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [twa_pkg::KIND_W-1:0]    i_kind,
    input  logic [twa_pkg::INDEX_W-1:0]   i_state_index,
    input  logic [twa_pkg::INDEX_W-1:0]   i_event_index,
    input  logic [twa_pkg::SYM_W-1:0]     i_symbol,
    input  logic [twa_pkg::ROW_W-1:0]     i_row_targets,
    input  logic                          i_final_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_verdict,
    output logic [twa_pkg::STATE_W-1:0]   o_end_state
);
    import twa_pkg::*;

    logic [CFG_W-1:0] r_state_count;
    logic [CFG_W-1:0] r_event_count;

    logic       push;
    logic       pop;
    t_job       job_in;
    t_job       job_out;
    t_fifo_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= CFG_W'(1);
            r_event_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATE_COUNT: r_state_count <= i_cfg_data;
                CFG_EVENT_COUNT: r_event_count <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    twa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_state_index (i_state_index),
        .i_event_index (i_event_index),
        .i_symbol      (i_symbol),
        .i_row_targets (i_row_targets),
        .i_final_value (i_final_value),
        .i_event_count (r_event_count),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_job         (job_in)
    );

    twa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (q_stat)
    );

    twa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_out),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .i_state_count (r_state_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_verdict     (o_verdict),
        .o_end_state   (o_end_state)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the table-driven word acceptor core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twa_pkg::*;

    localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 155;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] si;
        logic [INDEX_W-1:0] ei;
        logic [SYM_W-1:0]   sym;
        logic [ROW_W-1:0]   targets;
        logic               fv;
    } word_item_t;

    typedef struct packed {
        t_verdict            verdict;
        logic [STATE_W-1:0]  end_state;
    } verdict_rec_t;

    typedef struct packed {
        logic                 is_cfg;
        logic                 typed;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]     cfg_val;
        word_item_t           it;
        verdict_rec_t         want;
    } plan_row_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind;
    logic [INDEX_W-1:0]   i_state_index;
    logic [INDEX_W-1:0]   i_event_index;
    logic [SYM_W-1:0]     i_symbol;
    logic [ROW_W-1:0]     i_row_targets;
    logic                 i_final_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_verdict;
    logic [STATE_W-1:0]   o_end_state;

    table_driven_word_acceptor_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_state_index (i_state_index),
        .i_event_index (i_event_index),
        .i_symbol      (i_symbol),
        .i_row_targets (i_row_targets),
        .i_final_value (i_final_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_verdict     (o_verdict),
        .o_end_state   (o_end_state)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0]   pr_state_cnt;
    logic [CFG_W-1:0]   pr_event_cnt;
    logic [STATE_W-1:0] pr_state;
    logic               pr_dead;
    t_verdict           pr_fail;
    logic [SYM_W-1:0]   pr_syms [MAX_EVENTS];
    logic [ROW_W-1:0]   pr_rows [MAX_STATES][MAX_EVENTS];
    logic               pr_finals [MAX_STATES];

    verdict_rec_t verdicts_due [$];
    plan_row_t    plan [$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  in_stall_cycles = 0;
    int  verdict_hits [4] = '{0, 0, 0, 0};
    int  burst_left = 0;
    bit  steady_feed = 1'b0;
    bit  hold_req = 1'b0;
    logic [SYM_W-1:0] sym_base = '0;

    function automatic int states_in_use();
        return (pr_state_cnt > MAX_STATES) ? MAX_STATES : int'(pr_state_cnt);
    endfunction

    function automatic int events_in_use();
        return (pr_event_cnt > MAX_EVENTS) ? MAX_EVENTS : int'(pr_event_cnt);
    endfunction

    function automatic bit acceptor_verdict(input word_item_t it, output verdict_rec_t rec);
        int n_st;
        int n_ev;
        int ev;
        int nxt;
        logic [ROW_W-1:0] row;
        n_st = states_in_use();
        n_ev = events_in_use();
        ev = -1;
        nxt = -1;
        rec = '0;
        case (it.kind)
            K_LOAD_SYM: pr_syms[it.ei] = it.sym;
            K_LOAD_ROW: pr_rows[it.si][it.ei] = it.targets;
            K_LOAD_FINAL: pr_finals[it.si] = it.fv;
            K_CHAR: begin
                if (!pr_dead) begin
                    for (int j = 0; j < n_ev; j++)
                        if (pr_syms[j] == it.sym) ev = j;
                    if (ev < 0) begin
                        pr_dead = 1'b1;
                        pr_fail = V_UNKNOWN;
                    end else begin
                        row = pr_rows[pr_state][ev];
                        if (n_st < ROW_W) row &= (ROW_W'(1) << n_st) - ROW_W'(1);
                        for (int j = 0; j < n_st; j++)
                            if (row[j]) nxt = j;
                        if (nxt < 0) begin
                            pr_dead = 1'b1;
                            pr_fail = V_NO_TRANS;
                        end else begin
                            pr_state = STATE_W'(nxt);
                        end
                    end
                end
            end
            K_EOW: begin
                rec.verdict = pr_dead ? pr_fail : (pr_finals[pr_state] ? V_ACCEPT : V_NONFINAL);
                rec.end_state = pr_state;
                pr_state = '0;
                pr_dead = 1'b0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic word_item_t scramble_item(input logic [KIND_W-1:0] kind);
        word_item_t it;
        it.kind = kind;
        it.si = INDEX_W'($urandom);
        it.ei = INDEX_W'($urandom);
        it.sym = SYM_W'($urandom);
        it.targets = ROW_W'($urandom);
        it.fv = 1'($urandom);
        return it;
    endfunction

    // loads steer walks into the low states and the events in use
    function automatic word_item_t rand_load();
        word_item_t it;
        int lo_st;
        int n_ev;
        lo_st = (states_in_use() < 6) ? states_in_use() : 6;
        n_ev = events_in_use();
        case ($urandom_range(0, 2))
            0: begin
                it = scramble_item(K_LOAD_SYM);
                if ($urandom_range(0, 9) < 7) it.sym = sym_base + SYM_W'($urandom_range(0, 5));
            end
            1: begin
                it = scramble_item(K_LOAD_ROW);
                if (lo_st > 0 && $urandom_range(0, 3) != 0)
                    it.si = INDEX_W'($urandom_range(0, lo_st - 1));
                if (n_ev > 0 && $urandom_range(0, 3) != 0)
                    it.ei = INDEX_W'($urandom_range(0, n_ev - 1));
                case ($urandom_range(0, 9))
                    0: it.targets = '0;
                    1, 2, 3, 4, 5: it.targets = ROW_W'(1) << $urandom_range(0, (lo_st > 0) ? lo_st - 1 : 0);
                    default: ;
                endcase
            end
            default: begin
                it = scramble_item(K_LOAD_FINAL);
                if (lo_st > 0 && $urandom_range(0, 3) != 0)
                    it.si = INDEX_W'($urandom_range(0, lo_st - 1));
            end
        endcase
        return it;
    endfunction

    function automatic void plan_item(input logic [KIND_W-1:0] kind,
                                      input logic [INDEX_W-1:0] si, input logic [INDEX_W-1:0] ei,
                                      input logic [SYM_W-1:0] sym, input logic [ROW_W-1:0] tg,
                                      input logic fv);
        plan_row_t r;
        r = '0;
        r.it = {kind, si, ei, sym, tg, fv};
        plan.push_back(r);
    endfunction

    function automatic void plan_verdict(input t_verdict v, input logic [STATE_W-1:0] st);
        plan_row_t r;
        r = '0;
        r.it.kind = K_EOW;
        r.typed = 1'b1;
        r.want.verdict = v;
        r.want.end_state = st;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        plan.push_back(r);
    endfunction

    task automatic send_item(input word_item_t it, input bit typed = 1'b0,
                             input verdict_rec_t want = '0);
        verdict_rec_t rec;
        int gap;
        if (burst_left <= 0) begin
            if (!steady_feed) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_kind = it.kind;
        i_state_index = it.si;
        i_event_index = it.ei;
        i_symbol = it.sym;
        i_row_targets = it.targets;
        i_final_value = it.fv;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (acceptor_verdict(it, rec)) verdicts_due.push_back(typed ? want : rec);
        if (it.kind <= K_EOW) items_sent++;
    endtask

    // drop valid, wait out every pending verdict, then let the back end go quiet
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        if (idx == CFG_STATE_COUNT) pr_state_cnt = val;
        else if (idx == CFG_EVENT_COUNT) pr_event_cnt = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        verdict_rec_t want;
        if (i_rst_n && i_in_valid && !o_in_ready) in_stall_cycles++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected verdict %0d end state %0d at %0t",
                             o_verdict, o_end_state, $time);
            end else begin
                want = verdicts_due.pop_front();
                verdict_hits[want.verdict]++;
                if (o_verdict !== want.verdict || o_end_state !== want.end_state) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t: verdict exp %0d got %0d, end state exp %0d got %0d",
                                 $time, want.verdict, o_verdict, want.end_state, o_end_state);
                end
            end
        end
    end

    initial begin
        rx_mode_e mode;
        int span_left;
        mode = RX_OPEN;
        span_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (span_left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    span_left = $urandom_range(8, 64);
                end
                span_left--;
                case (mode)
                    RX_OPEN: i_out_ready = 1'b1;
                    RX_COIN: i_out_ready = 1'($urandom);
                    RX_SPARSE: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = (span_left % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("table_driven_word_acceptor_core test failed");
        $finish;
    end

    initial begin
        word_item_t it;
        logic [CFG_W-1:0] sc;
        logic [CFG_W-1:0] ec;
        int sent;
        int wlen;
        int pick;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_kind = '0;
        i_state_index = '0;
        i_event_index = '0;
        i_symbol = '0;
        i_row_targets = '0;
        i_final_value = 1'b0;

        pr_state_cnt = CFG_W'(1);
        pr_event_cnt = '0;
        pr_state = '0;
        pr_dead = 1'b0;
        pr_fail = V_ACCEPT;
        for (int s = 0; s < MAX_STATES; s++) begin
            pr_finals[s] = 1'b0;
            for (int e = 0; e < MAX_EVENTS; e++) pr_rows[s][e] = '0;
        end
        for (int e = 0; e < MAX_EVENTS; e++) pr_syms[e] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: one state, no events
        plan_verdict(V_NONFINAL, 4'd0);
        plan_item(K_CHAR, 4'hF, 4'hF, 8'hFF, 16'hFFFF, 1'b1);
        plan_verdict(V_UNKNOWN, 4'd0);
        plan_cfg(CFG_STATE_COUNT, 5'd16);
        plan_cfg(CFG_EVENT_COUNT, 5'd31);
        plan_item(K_LOAD_SYM, 4'h0, 4'hF, 8'h00, 16'h0000, 1'b0);
        plan_item(K_LOAD_SYM, 4'hF, 4'h0, 8'hFF, 16'hFFFF, 1'b1);
        plan_item(K_LOAD_ROW, 4'h0, 4'hF, 8'h00, 16'hFFFF, 1'b0);
        plan_item(K_LOAD_ROW, 4'hF, 4'h0, 8'hFF, 16'h0001, 1'b1);
        plan_item(K_LOAD_FINAL, 4'hF, 4'h0, 8'h00, 16'h0000, 1'b1);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b0);
        plan_verdict(V_ACCEPT, 4'd15);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b0);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'hFF, 16'h0000, 1'b0);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'hFF, 16'h0000, 1'b0);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b0);
        plan_verdict(V_NO_TRANS, 4'd0);
        plan_item(K_SPARE_LAST, 4'hF, 4'hF, 8'hFF, 16'hFFFF, 1'b1);
        plan_item(K_LOAD_FINAL, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b1);
        plan_verdict(V_ACCEPT, 4'd0);
        plan_cfg(CFG_STATE_COUNT, 5'd0);
        plan_verdict(V_ACCEPT, 4'd0);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b0);
        plan_verdict(V_NO_TRANS, 4'd0);
        plan_cfg(CFG_EVENT_COUNT, 5'd0);
        plan_cfg(CFG_STATE_COUNT, 5'd31);
        plan_item(K_CHAR, 4'h0, 4'h0, 8'h00, 16'h0000, 1'b0);
        plan_verdict(V_UNKNOWN, 4'd0);
        plan_item(K_LOAD_FINAL, 4'hF, 4'h0, 8'h00, 16'h0000, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_and_settle();
                write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                send_item(plan[i].it, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin sc = 5'd16; ec = 5'd16; end
                1: begin sc = 5'd4;  ec = 5'd8;  end
                2: begin sc = 5'd0;  ec = 5'd16; end
                3: begin sc = 5'd31; ec = 5'd31; end
                4: begin sc = 5'd1;  ec = 5'd1;  end
                5: begin sc = 5'd2;  ec = 5'd3;  end
                6: begin sc = 5'd17; ec = 5'd0;  end
                7: begin sc = 5'd8;  ec = 5'd16; end
                8: begin sc = 5'd6;  ec = 5'd12; end
                default: begin sc = CFG_W'($urandom); ec = CFG_W'($urandom); end
            endcase
            drain_and_settle();
            write_cfg(CFG_STATE_COUNT, sc);
            write_cfg(CFG_EVENT_COUNT, ec);
            sym_base = SYM_W'($urandom);
            steady_feed = (ph == 3 || ph == 7);
            // block the output long enough for the queue to fill
            if (ph == 3) hold_req = 1'b1;
            sent = 0;
            repeat (10) begin
                send_item(rand_load());
                sent++;
            end
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    send_item(rand_load());
                    sent++;
                end else if (pick < 16) begin
                    send_item(scramble_item(KIND_W'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST))));
                end else begin
                    wlen = $urandom_range(0, 8);
                    repeat (wlen) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_item(rand_load());
                            sent++;
                        end
                        it = scramble_item(K_CHAR);
                        if (events_in_use() > 0 && $urandom_range(0, 9) < 8)
                            it.sym = pr_syms[$urandom_range(0, events_in_use() - 1)];
                        send_item(it);
                        sent++;
                    end
                    send_item(scramble_item(K_EOW));
                    sent++;
                end
            end
        end
        steady_feed = 1'b0;
        drain_and_settle();

        $display("covered %0d items and %0d register writes; verdicts seen: accept %0d, nonfinal %0d,",
                 items_sent, cfg_writes, verdict_hits[V_ACCEPT], verdict_hits[V_NONFINAL]);
        $display("unknown symbol %0d, no transition %0d; input held off for %0d cycles",
                 verdict_hits[V_UNKNOWN], verdict_hits[V_NO_TRANS], in_stall_cycles);
        if (mismatch_count == 0 && verdicts_due.size() == 0) begin
            $display("table_driven_word_acceptor_core test passed");
        end else begin
            $display("%0d mismatches, %0d verdicts never arrived",
                     mismatch_count, verdicts_due.size());
            $display("table_driven_word_acceptor_core test failed");
        end
        $finish;
    end

endmodule

@@ table_driven_word_acceptor_core.f @@
rtl/twa_pkg.sv
rtl/twa_front.sv
rtl/twa_fifo.sv
rtl/twa_back.sv
rtl/table_driven_word_acceptor_core.sv
tb/tb_top.sv
